// ----- src/rdpd_pkg.sv -----
// shared types and constants for the debug-link packet deframer
// no dependencies

package rdpd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 3;

	localparam logic [ByteW-1:0] CH_ACK  = 8'h2B;
	localparam logic [ByteW-1:0] CH_NAK  = 8'h2D;
	localparam logic [ByteW-1:0] CH_PKT  = 8'h24;
	localparam logic [ByteW-1:0] CH_NOTE = 8'h25;
	localparam logic [ByteW-1:0] CH_HASH = 8'h23;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_SUM1 = 2'd2,
		PH_SUM2 = 2'd3
	} phase_t;

	typedef enum logic [KindW-1:0] {
		K_PAYLOAD  = 3'd0,
		K_PKT_END  = 3'd1,
		K_NOTE_END = 3'd2,
		K_ACK      = 3'd3,
		K_NAK      = 3'd4,
		K_GARBAGE  = 3'd5
	} kind_t;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [ByteW-1:0] data;
	} result_t;

endpackage

// ----- src/rdpd_decode.sv -----
// phase machine and byte classifier of the deframer
// depends on rdpd_pkg

module rdpd_decode
	import rdpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [ByteW-1:0] byte_in,
	output result_t          res
);

	phase_t phase_q, phase_d;
	logic   note_q, note_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			note_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			note_q  <= note_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		note_d    = note_q;
		res.valid = 1'b0;
		res.kind  = K_PAYLOAD;
		res.data  = '0;
		case (phase_q)
			PH_IDLE: begin
				if (byte_in == CH_ACK) begin
					res.valid = 1'b1;
					res.kind  = K_ACK;
				end else if (byte_in == CH_NAK) begin
					res.valid = 1'b1;
					res.kind  = K_NAK;
				end else if (byte_in == CH_PKT || byte_in == CH_NOTE) begin
					note_d  = (byte_in == CH_NOTE);
					phase_d = PH_BODY;
				end else begin
					res.valid = 1'b1;
					res.kind  = K_GARBAGE;
					res.data  = byte_in;
				end
			end
			PH_BODY: begin
				if (byte_in == CH_HASH) begin
					phase_d = PH_SUM1;
				end else begin
					res.valid = 1'b1;
					res.kind  = K_PAYLOAD;
					res.data  = byte_in;
				end
			end
			PH_SUM1: begin
				phase_d = PH_SUM2;
			end
			PH_SUM2: begin
				phase_d   = PH_IDLE;
				res.valid = 1'b1;
				res.kind  = note_q ? K_NOTE_END : K_PKT_END;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

endmodule

// ----- src/remote_debug_packet_deframer.sv -----
// a byte is taken into the input register, and its result into the output register once the output can advance
// throughput: one byte per cycle, limited only by back-pressure on the output
// an input register feeds the phase machine, whose result lands in the output register
// bytes that give no result (frame openers, '#', the first checksum byte) use no output slot
// reset (arst_n low, asynchronous) empties both registers and returns to idle
// depends on rdpd_pkg and rdpd_decode

module remote_debug_packet_deframer
	import rdpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [ByteW-1:0] s_axis_tdata,  // [7:0] byte_in
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [ByteW-1:0] m_axis_tdata,  // [7:0] byte_out
	output logic [KindW-1:0] m_axis_tuser   // [2:0] kind
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_valid_q;
	logic [ByteW-1:0] out_data_q;
	kind_t            out_kind_q;
	logic             advance;
	logic             fire;
	result_t          res;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	rdpd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_in (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			out_data_q <= res.data;
			out_kind_q <= res.kind;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

endmodule

// ----- src/rdpd_checker.sv -----
// port-level checks for the deframer, bound to the top level
// depends on rdpd_pkg

module rdpd_checker
	import rdpd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [ByteW-1:0] m_axis_tdata,
	input logic [KindW-1:0] m_axis_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser <= K_GARBAGE)
		else $error("kind out of range");

	// only payload and garbage carry a byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == K_PKT_END || m_axis_tuser == K_NOTE_END ||
			m_axis_tuser == K_ACK || m_axis_tuser == K_NAK) |-> m_axis_tdata == '0)
		else $error("non-zero byte on a control result");

	// a result starting from an empty output needs a matching input transfer, passed through the input register
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without a matching input transfer");

endmodule

bind remote_debug_packet_deframer rdpd_checker u_rdpd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
